@@ src/wss_pkg.sv @@
// Shared constants for the windowed sensor statistics block.
// No dependencies.
`default_nettype none
package wss_pkg;
    localparam int DEF_WINDOW_DEPTH = 16;
    localparam int DEF_NUM_SENSORS  = 8;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int MEAN_BITS        = 20;
    localparam int FRAC_BITS        = 4;
    localparam longint MEAN_POS_MAX = 524287;
    localparam longint MEAN_NEG_MAG = 524288;
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;
endpackage
`default_nettype wire

@@ src/windowed_sensor_statistics.sv @@
// Windowed sensor statistics: per-sensor and overall sliding windows with a
// sequenced min/max/mean/median report. Uses wss_pkg.
//
// Usage:
// Input channel i_valid/o_ready carries a command. A push (cmd 0) stores the
// sample in the sensor's ring and in the overall ring; after the transfer
// o_ready stays low while the single window memory port makes one write per
// ring, so a new push is not taken until both writes are done. Pushes with an
// id at or above NUM_SENSORS are dropped. A report (cmd 1) produces one
// result per non-empty sensor in ascending id, then the overall result with
// o_last set (o_empty_res set when the overall window is empty).
// Each slot is first checked in the scan state. A non-empty window of n
// entries is walked through one compare unit for min/max/sum/median, then a
// bit-serial divider on the sum, shifted left by FRAC_BITS, gives the mean,
// then the output register is loaded. o_ready is low for the whole report.
// Results sit in an output register; a stalled receiver (i_ready low) holds
// the sequencer in its emit state until the waiting result is taken. Once
// the last result is loaded, pushes are taken while it waits.
// Reset (synchronous, active low) empties all windows; window memory contents
// are not cleared.
`default_nettype none
module windowed_sensor_statistics #(
    parameter int WINDOW_DEPTH = wss_pkg::DEF_WINDOW_DEPTH,
    parameter int NUM_SENSORS  = wss_pkg::DEF_NUM_SENSORS,
    parameter int SAMPLE_BITS  = wss_pkg::DEF_SAMPLE_BITS,
    localparam int IDW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1,
    localparam int SW  = $clog2(NUM_SENSORS + 1),
    localparam int MB  = wss_pkg::MEAN_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_cmd,
    input  wire [IDW-1:0]                i_sensor_id,
    input  wire signed [SAMPLE_BITS-1:0] i_sample_value,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [SW-1:0]                o_source_id,
    output logic                         o_empty_res,
    output logic signed [SAMPLE_BITS-1:0] o_max_value,
    output logic signed [SAMPLE_BITS-1:0] o_min_value,
    output logic signed [MB-1:0]         o_mean_fixed,
    output logic signed [SAMPLE_BITS-1:0] o_median_value,
    output logic                         o_last
);
    localparam int SB    = SAMPLE_BITS;
    localparam int HW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOTS = NUM_SENSORS + 1;
    localparam int MDEP  = SLOTS * WINDOW_DEPTH;
    localparam int AW    = (MDEP > 1) ? $clog2(MDEP) : 1;
    localparam int SUMW  = SB + CW;
    localparam int DW    = SUMW + wss_pkg::FRAC_BITS;
    localparam int STW   = $clog2(DW + 1);
    localparam int QW    = (DW > MB + 1) ? DW : MB + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PUSH, ST_SCAN, ST_CAND, ST_CGET,
        ST_INNER, ST_CHECK, ST_DIV, ST_EMIT
    } t_state;

    t_state                r_state;
    logic [SW-1:0]         r_slot;
    logic signed [SB-1:0]  r_val;
    logic [CW-1:0]         r_cnt  [SLOTS];
    logic [HW-1:0]         r_head [SLOTS];
    logic [CW-1:0]         r_n, r_i, r_j, r_k, r_lt, r_eq;
    logic signed [SB-1:0]  r_cand, r_min, r_max, r_med;
    logic signed [SUMW-1:0] r_sum;
    logic [DW-1:0]         r_dvd;
    logic [CW:0]           r_rem;
    logic [STW-1:0]        r_step;
    logic                  r_neg, r_empty;
    logic signed [SB-1:0]  r_rd;
    logic signed [SB-1:0]  r_mem [MDEP];

    logic                  r_o_valid, r_o_empty, r_o_last;
    logic [SW-1:0]         r_o_src;
    logic signed [SB-1:0]  r_o_max, r_o_min, r_o_med;
    logic signed [MB-1:0]  r_o_mean;

    logic [CW-1:0]   w_cnt;
    logic [HW-1:0]   w_head;
    logic [CW:0]     w_wsum;
    logic [HW-1:0]   w_widx;
    logic [HW-1:0]   w_idx;
    logic [AW-1:0]   w_addr;
    logic [SUMW-1:0] w_mag;
    logic [CW:0]     w_rem2;
    logic [QW-1:0]   w_q;
    logic signed [MB-1:0] w_mean;
    logic [CW-1:0]   w_half;
    logic            w_lt, w_eq;
    logic            w_load;

    always_comb begin
        w_cnt  = r_cnt[r_slot];
        w_head = r_head[r_slot];
        w_wsum = (CW+1)'(w_head) + (CW+1)'(w_cnt);
        if (w_wsum >= (CW+1)'(WINDOW_DEPTH)) begin
            w_wsum = w_wsum - (CW+1)'(WINDOW_DEPTH);
        end
        w_widx = w_wsum[HW-1:0];
        case (r_state)
            ST_PUSH:  w_idx = w_widx;
            ST_CGET:  w_idx = '0;
            ST_INNER: w_idx = r_j[HW-1:0];
            default:  w_idx = r_i[HW-1:0];
        endcase
        w_addr = AW'(r_slot) * AW'(WINDOW_DEPTH) + AW'(w_idx);
        w_mag  = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
        w_rem2 = {r_rem[CW-1:0], r_dvd[DW-1]};
        w_q    = QW'(r_dvd);
        if (r_neg) begin
            w_mean = (w_q > QW'(wss_pkg::MEAN_NEG_MAG)) ? MB'(wss_pkg::MEAN_NEG_MAG)
                                                       : MB'(-w_q);
        end else begin
            w_mean = (w_q > QW'(wss_pkg::MEAN_POS_MAX)) ? MB'(wss_pkg::MEAN_POS_MAX)
                                                       : MB'(w_q);
        end
        w_half = r_n >> 1;
        w_lt   = r_rd < r_cand;
        w_eq   = r_rd == r_cand;
        w_load = (r_state == ST_EMIT) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH) begin
            r_mem[w_addr] <= r_val;
        end
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= '0;
            r_o_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt[s]  <= '0;
                r_head[s] <= '0;
            end
        end else begin
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_cmd == wss_pkg::CMD_REPORT) begin
                            r_slot  <= '0;
                            r_state <= ST_SCAN;
                        end else if (32'(i_sensor_id) < NUM_SENSORS) begin
                            r_slot  <= SW'(i_sensor_id);
                            r_val   <= i_sample_value;
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_PUSH: begin
                    if (w_cnt < CW'(WINDOW_DEPTH)) begin
                        r_cnt[r_slot] <= w_cnt + CW'(1);
                    end else begin
                        r_head[r_slot] <= (32'(w_head) == WINDOW_DEPTH - 1) ? '0
                                                                   : w_head + HW'(1);
                    end
                    if (r_slot == SW'(NUM_SENSORS)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_slot <= SW'(NUM_SENSORS);
                    end
                end
                ST_SCAN: begin
                    r_n     <= w_cnt;
                    r_i     <= '0;
                    r_empty <= (w_cnt == '0);
                    if (w_cnt != '0) begin
                        r_state <= ST_CAND;
                    end else if (r_slot == SW'(NUM_SENSORS)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_slot <= r_slot + SW'(1);
                    end
                end
                ST_CAND: begin
                    r_state <= ST_CGET;
                end
                ST_CGET: begin
                    r_cand <= r_rd;
                    if (r_i == '0) begin
                        r_min <= r_rd;
                        r_max <= r_rd;
                        r_sum <= SUMW'(r_rd);
                    end else begin
                        if (r_rd < r_min) r_min <= r_rd;
                        if (r_rd > r_max) r_max <= r_rd;
                        r_sum <= r_sum + SUMW'(r_rd);
                    end
                    r_lt    <= '0;
                    r_eq    <= '0;
                    r_k     <= '0;
                    r_j     <= CW'(1);
                    r_state <= ST_INNER;
                end
                ST_INNER: begin
                    if (w_lt) r_lt <= r_lt + CW'(1);
                    if (w_eq) r_eq <= r_eq + CW'(1);
                    r_k <= r_k + CW'(1);
                    r_j <= r_j + CW'(1);
                    if (r_k == r_n - CW'(1)) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (r_lt <= w_half && (CW+1)'(w_half) < (CW+1)'(r_lt) + (CW+1)'(r_eq)) begin
                        r_med <= r_cand;
                    end
                    r_i <= r_i + CW'(1);
                    if (r_i == r_n - CW'(1)) begin
                        r_neg   <= r_sum[SUMW-1];
                        r_dvd   <= {w_mag, wss_pkg::FRAC_BITS'(0)};
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_CAND;
                    end
                end
                ST_DIV: begin
                    if (w_rem2 >= (CW+1)'(r_n)) begin
                        r_rem <= w_rem2 - (CW+1)'(r_n);
                        r_dvd <= {r_dvd[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    end
                    r_step <= r_step + STW'(1);
                    if (r_step == STW'(DW - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_o_src   <= r_slot;
                        r_o_empty <= r_empty;
                        r_o_max   <= r_empty ? '0 : r_max;
                        r_o_min   <= r_empty ? '0 : r_min;
                        r_o_med   <= r_empty ? '0 : r_med;
                        r_o_mean  <= r_empty ? '0 : w_mean;
                        r_o_last  <= r_slot == SW'(NUM_SENSORS);
                        if (r_slot == SW'(NUM_SENSORS)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_slot  <= r_slot + SW'(1);
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready        = r_state == ST_IDLE;
    assign o_valid        = r_o_valid;
    assign o_source_id    = r_o_src;
    assign o_empty_res    = r_o_empty;
    assign o_max_value    = r_o_max;
    assign o_min_value    = r_o_min;
    assign o_mean_fixed   = r_o_mean;
    assign o_median_value = r_o_med;
    assign o_last         = r_o_last;

    a_last_is_overall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_source_id == SW'(NUM_SENSORS))
        else $error("last result not from overall window");
    a_empty_only_overall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last)
        else $error("empty result from a sensor window");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PUSH |-> w_cnt <= CW'(WINDOW_DEPTH))
        else $error("window count above depth");
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_res |-> o_min_value <= o_median_value
                                   && o_median_value <= o_max_value)
        else $error("median outside min/max");
endmodule
`default_nettype wire
